// ===== rtl/core/onewire_bus_master_macros.svh =====
// assertion macros for the 1-wire master rtl
`ifndef ONEWIRE_BUS_MASTER_MACROS_SVH
`define ONEWIRE_BUS_MASTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every clock edge out of reset
`define OWB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define OWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OWB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define OWB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/onewb_pkg.sv =====
package onewb_pkg;

	// configuration register map, one word each at byte address 4*i
	localparam int CFG_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE      = 3'd1,
		REG_RELEASE       = 3'd2,
		REG_SHORT_SLOT    = 3'd3,
		REG_LONG_SLOT     = 3'd4,
		REG_READ_LOW      = 3'd5,
		REG_READ_SAMPLE   = 3'd6,
		REG_READ_RECOVERY = 3'd7
	} reg_idx_t;

	// reset defaults, in microseconds
	localparam logic [9:0] RST_RESET_LOW     = 10'd640;
	localparam logic [7:0] RST_PRESENCE      = 8'd60;
	localparam logic [9:0] RST_RELEASE       = 10'd240;
	localparam logic [5:0] RST_SHORT_SLOT    = 6'd5;
	localparam logic [7:0] RST_LONG_SLOT     = 8'd90;
	localparam logic [5:0] RST_READ_LOW      = 6'd2;
	localparam logic [5:0] RST_READ_SAMPLE   = 6'd8;
	localparam logic [7:0] RST_READ_RECOVERY = 8'd80;

	typedef struct packed {
		logic [9:0] reset_low_time;
		logic [7:0] presence_sample_time;
		logic [9:0] release_timeout;
		logic [5:0] short_slot_time;
		logic [7:0] long_slot_time;
		logic [5:0] read_low_time;
		logic [5:0] read_sample_time;
		logic [7:0] read_recovery_time;
	} cfg_t;

	// command carried with each tick
	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_RESET = 2'd1,
		ACT_WRITE = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	// bus status reported on done
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_PRESENCE = 2'd1,
		ST_STUCK_LOW   = 2'd2
	} status_t;

	// bus phases, one-hot
	typedef enum logic [8:0] {
		PH_IDLE     = 9'b000000001,
		PH_RST_LOW  = 9'b000000010,
		PH_RST_WAIT = 9'b000000100,
		PH_RST_REL  = 9'b000001000,
		PH_W_LOW    = 9'b000010000,
		PH_W_HIGH   = 9'b000100000,
		PH_R_LOW    = 9'b001000000,
		PH_R_WAIT   = 9'b010000000,
		PH_R_REC    = 9'b100000000
	} phase_t;

	// one result item
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [1:0] status;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} res_t;

endpackage

// ===== rtl/core/onewb_regs.sv =====
module onewb_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [onewb_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output onewb_pkg::cfg_t                   cfg
);

	onewb_pkg::cfg_t    cfg_q;
	onewb_pkg::reg_idx_t idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = onewb_pkg::reg_idx_t'(paddr[onewb_pkg::CFG_ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_time       <= onewb_pkg::RST_RESET_LOW;
			cfg_q.presence_sample_time <= onewb_pkg::RST_PRESENCE;
			cfg_q.release_timeout      <= onewb_pkg::RST_RELEASE;
			cfg_q.short_slot_time      <= onewb_pkg::RST_SHORT_SLOT;
			cfg_q.long_slot_time       <= onewb_pkg::RST_LONG_SLOT;
			cfg_q.read_low_time        <= onewb_pkg::RST_READ_LOW;
			cfg_q.read_sample_time     <= onewb_pkg::RST_READ_SAMPLE;
			cfg_q.read_recovery_time   <= onewb_pkg::RST_READ_RECOVERY;
		end else if (wr_en) begin
			unique case (idx)
				onewb_pkg::REG_RESET_LOW:     cfg_q.reset_low_time       <= pwdata[9:0];
				onewb_pkg::REG_PRESENCE:      cfg_q.presence_sample_time <= pwdata[7:0];
				onewb_pkg::REG_RELEASE:       cfg_q.release_timeout      <= pwdata[9:0];
				onewb_pkg::REG_SHORT_SLOT:    cfg_q.short_slot_time      <= pwdata[5:0];
				onewb_pkg::REG_LONG_SLOT:     cfg_q.long_slot_time       <= pwdata[7:0];
				onewb_pkg::REG_READ_LOW:      cfg_q.read_low_time        <= pwdata[5:0];
				onewb_pkg::REG_READ_SAMPLE:   cfg_q.read_sample_time     <= pwdata[5:0];
				onewb_pkg::REG_READ_RECOVERY: cfg_q.read_recovery_time   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		unique case (idx)
			onewb_pkg::REG_RESET_LOW:     prdata = {22'd0, cfg_q.reset_low_time};
			onewb_pkg::REG_PRESENCE:      prdata = {24'd0, cfg_q.presence_sample_time};
			onewb_pkg::REG_RELEASE:       prdata = {22'd0, cfg_q.release_timeout};
			onewb_pkg::REG_SHORT_SLOT:    prdata = {26'd0, cfg_q.short_slot_time};
			onewb_pkg::REG_LONG_SLOT:     prdata = {24'd0, cfg_q.long_slot_time};
			onewb_pkg::REG_READ_LOW:      prdata = {26'd0, cfg_q.read_low_time};
			onewb_pkg::REG_READ_SAMPLE:   prdata = {26'd0, cfg_q.read_sample_time};
			onewb_pkg::REG_READ_RECOVERY: prdata = {24'd0, cfg_q.read_recovery_time};
			default:                      prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/onewb_fsm.sv =====
module onewb_fsm #(
	parameter int TIME_WIDTH = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  onewb_pkg::cfg_t     cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	input  logic [7:0]          tx_byte,
	input  logic                line_level,
	output logic                out_valid,
	input  logic                out_ready,
	output onewb_pkg::res_t     res
);

	`include "onewire_bus_master_macros.svh"

	// compare width covers the widest register and the clamp value
	localparam int LW = ((TIME_WIDTH > 10) ? TIME_WIDTH : 10) + 1;

	onewb_pkg::phase_t      phase_q, ph_start, ph;
	logic [TIME_WIDTH-1:0]  time_count_q, tc;
	logic [2:0]             bit_count_q, bc;
	logic [7:0]             shift_byte_q, sb_start, sb;
	onewb_pkg::res_t        res_s1, r;
	logic                   out_valid_q;
	logic                   step;
	logic                   hit;
	logic [9:0]             len;

	// true when this tick is the last of a phase of length len
	function automatic logic phase_last(input logic [TIME_WIDTH-1:0] cnt,
					     input logic [9:0] plen);
		logic [LW-1:0] lim;
		logic [LW-1:0] l;
		logic [LW-1:0] nxt;
		lim = LW'(1) << TIME_WIDTH;
		l   = LW'(plen);
		if (l > lim) begin
			l = lim;
		end
		nxt = LW'(cnt) + LW'(1);
		return nxt >= l;
	endfunction

	// a tick is taken whenever the result register is free or draining
	assign in_ready  = !out_valid_q || out_ready;
	assign step      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign res       = res_s1;

	// phase length selected by the current (post-start) phase
	always_comb begin
		len      = 10'd0;
		ph_start = phase_q;
		sb_start = shift_byte_q;
		if (phase_q == onewb_pkg::PH_IDLE && action != onewb_pkg::ACT_TICK) begin
			if (action == onewb_pkg::ACT_RESET) begin
				ph_start = onewb_pkg::PH_RST_LOW;
			end else if (action == onewb_pkg::ACT_WRITE) begin
				ph_start = onewb_pkg::PH_W_LOW;
				sb_start = tx_byte;
			end else begin
				ph_start = onewb_pkg::PH_R_LOW;
				sb_start = 8'd0;
			end
		end
		unique case (ph_start)
			onewb_pkg::PH_RST_LOW:  len = cfg.reset_low_time;
			onewb_pkg::PH_RST_WAIT: len = {2'd0, cfg.presence_sample_time};
			onewb_pkg::PH_RST_REL:  len = cfg.release_timeout;
			onewb_pkg::PH_W_LOW:    len = sb_start[0] ? {4'd0, cfg.short_slot_time}
			                                          : {2'd0, cfg.long_slot_time};
			onewb_pkg::PH_W_HIGH:   len = sb_start[0] ? {2'd0, cfg.long_slot_time}
			                                          : {4'd0, cfg.short_slot_time};
			onewb_pkg::PH_R_LOW:    len = {4'd0, cfg.read_low_time};
			onewb_pkg::PH_R_WAIT:   len = {4'd0, cfg.read_sample_time};
			onewb_pkg::PH_R_REC:    len = {2'd0, cfg.read_recovery_time};
			default:                len = 10'd0;
		endcase
	end

	// one tick of the bus sequencer
	always_comb begin
		ph = ph_start;
		sb = sb_start;
		tc = time_count_q;
		bc = bit_count_q;
		r  = '0;
		if (phase_q == onewb_pkg::PH_IDLE && action != onewb_pkg::ACT_TICK) begin
			tc = '0;
			bc = 3'd0;
		end
		hit = phase_last(tc, len);
		r.busy_res = (ph != onewb_pkg::PH_IDLE);
		unique case (ph)
			onewb_pkg::PH_IDLE: begin
			end
			onewb_pkg::PH_RST_LOW: begin
				r.drive_low = 1'b1;
				if (hit) begin
					ph = onewb_pkg::PH_RST_WAIT;
				end
			end
			onewb_pkg::PH_RST_WAIT: begin
				if (hit) begin
					if (line_level) begin
						r.done_res = 1'b1;
						r.status   = onewb_pkg::ST_NO_PRESENCE;
						ph         = onewb_pkg::PH_IDLE;
					end else begin
						ph = onewb_pkg::PH_RST_REL;
					end
				end
			end
			onewb_pkg::PH_RST_REL: begin
				// device let go: done, timer cleared without advancing
				if (line_level) begin
					hit        = 1'b1;
					r.done_res = 1'b1;
					r.status   = onewb_pkg::ST_OK;
					ph         = onewb_pkg::PH_IDLE;
				end else if (hit) begin
					r.done_res = 1'b1;
					r.status   = onewb_pkg::ST_STUCK_LOW;
					ph         = onewb_pkg::PH_IDLE;
				end
			end
			onewb_pkg::PH_W_LOW: begin
				r.drive_low = 1'b1;
				if (hit) begin
					ph = onewb_pkg::PH_W_HIGH;
				end
			end
			onewb_pkg::PH_W_HIGH: begin
				if (hit) begin
					sb = {1'b0, sb[7:1]};
					if (bc == 3'd7) begin
						r.done_res = 1'b1;
						ph         = onewb_pkg::PH_IDLE;
					end else begin
						bc = bc + 3'd1;
						ph = onewb_pkg::PH_W_LOW;
					end
				end
			end
			onewb_pkg::PH_R_LOW: begin
				r.drive_low = 1'b1;
				if (hit) begin
					ph = onewb_pkg::PH_R_WAIT;
				end
			end
			onewb_pkg::PH_R_WAIT: begin
				if (hit) begin
					sb = {line_level, sb[7:1]};
					ph = onewb_pkg::PH_R_REC;
				end
			end
			onewb_pkg::PH_R_REC: begin
				if (hit) begin
					if (bc == 3'd7) begin
						r.done_res = 1'b1;
						r.rx_byte  = sb;
						ph         = onewb_pkg::PH_IDLE;
					end else begin
						bc = bc + 3'd1;
						ph = onewb_pkg::PH_R_LOW;
					end
				end
			end
			default: begin
				ph         = onewb_pkg::PH_IDLE;
				hit        = 1'b1;
				r.busy_res = 1'b0;
			end
		endcase
		// phase timer: wraps on the last tick, else counts up
		if (ph != onewb_pkg::PH_IDLE || phase_q != onewb_pkg::PH_IDLE) begin
			tc = hit ? '0 : tc + 1'b1;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= onewb_pkg::PH_IDLE;
			time_count_q <= '0;
			bit_count_q  <= 3'd0;
			shift_byte_q <= 8'd0;
		end else if (step) begin
			phase_q      <= ph;
			time_count_q <= tc;
			bit_count_q  <= bc;
			shift_byte_q <= sb;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_s1 <= r;
		end
	end

	`OWB_ASSERT_IMPL(a_done_busy, clk, arst_n, out_valid_q && res_s1.done_res,
		res_s1.busy_res, "done reported outside an operation")
	`OWB_ASSERT_IMPL(a_no_drive_on_done, clk, arst_n, out_valid_q && res_s1.done_res,
		!res_s1.drive_low, "bus still driven low on the completing tick")
	`OWB_ASSERT_IMPL(a_status_on_done, clk, arst_n,
		out_valid_q && (res_s1.status != onewb_pkg::ST_OK || res_s1.rx_byte != 8'd0),
		res_s1.done_res, "status or received byte outside a done tick")
	`OWB_ASSERT_NEXT(a_step_fills, clk, arst_n, step, out_valid_q,
		"accepted tick left no result")

endmodule

// ===== rtl/core/onewire_bus_master.sv =====
// channel   | dir | signals                                     | carries
// ----------+-----+---------------------------------------------+---------------------------
// s_        | in  | s_tvalid s_tready s_tdata[15:0] s_tuser[1:0] | one microsecond tick
// m_        | out | m_tvalid m_tready m_tdata[15:0]             | bus outputs for that tick
// apb       | in  | psel penable pwrite paddr pwdata prdata pready | timing registers
//
// one result per tick; a tick is taken every cycle while the result register
// is empty or being drained, so a sustained rate of one tick per clock
// a tick passes from the slave side through the phase sequencer into the
// result register combinationally and is registered there
// reset clears the sequencer to idle and loads the default bus timings
// a stall on the master side holds the result and blocks new ticks
module onewire_bus_master #(
	parameter int TIME_WIDTH = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// apb configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [onewb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	// tick input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // tx_byte[7:0], line_level[8], zero
	input  logic [1:0]                       s_tuser,  // action[1:0]
	// tick result
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata   // drive_low, busy_res, done_res,
	                                                   // status[4:3], rx_byte[12:5], zero
);

	onewb_pkg::cfg_t cfg;
	onewb_pkg::res_t res;

	// timing registers
	onewb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// bus sequencer with result register
	onewb_fsm #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser),
		.tx_byte    (s_tdata[7:0]),
		.line_level (s_tdata[8]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.res        (res)
	);

	// pack result transfer
	assign m_tdata = {3'd0, res};

endmodule

// ===== tb/onewire_bus_master_checker.sv =====
`timescale 1ns / 100ps

module onewire_bus_master_checker import onewb_pkg::*; #(
	parameter int TIME_WIDTH = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	// tick transfers
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [15:0]           s_tdata,  // tx_byte[7:0], line_level[8], zero
	input  logic [1:0]            s_tuser,  // action[1:0]
	// result transfers
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [15:0]           m_tdata,  // drive_low, busy_res, done_res,
	                                        // status[4:3], rx_byte[12:5], zero
	output int                    errors,
	output int                    outstanding,
	output logic                  seq_busy,
	output int                    resets_ok,
	output int                    resets_absent,
	output int                    resets_stuck,
	output int                    bytes_written,
	output int                    bytes_read
);

	localparam int unsigned TIMER_SPAN = 1 << TIME_WIDTH;

	// bus sequencer mirror
	cfg_t        timing;
	phase_t      ph;
	int unsigned tcount;
	logic [2:0]  bcount;
	logic [7:0]  shreg;
	action_t     kind;

	res_t        tick_results_q[$];

	// advance the phase timer, true on the last tick of a phase
	function automatic logic slot_over(input int unsigned len);
		if (len > TIMER_SPAN)
			len = TIMER_SPAN;
		if (tcount + 1 >= len) begin
			tcount = 0;
			return 1'b1;
		end
		tcount++;
		return 1'b0;
	endfunction

	// one microsecond of the bus master: drive, flags and read byte for this tick
	function automatic res_t bus_tick(input action_t act, input logic [7:0] tx, input logic line);
		res_t r;
		r = '0;
		if (ph == PH_IDLE && act != ACT_TICK) begin
			kind   = act;
			tcount = 0;
			bcount = '0;
			case (act)
				ACT_RESET: ph = PH_RST_LOW;
				ACT_WRITE: begin
					shreg = tx;
					ph    = PH_W_LOW;
				end
				default: begin
					shreg = '0;
					ph    = PH_R_LOW;
				end
			endcase
		end
		r.busy_res = (ph != PH_IDLE);
		case (ph)
			PH_IDLE: ;
			PH_RST_LOW: begin
				r.drive_low = 1'b1;
				if (slot_over(timing.reset_low_time))
					ph = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				if (slot_over(timing.presence_sample_time)) begin
					if (line) begin
						r.done_res = 1'b1;
						r.status   = ST_NO_PRESENCE;
						ph         = PH_IDLE;
					end else begin
						ph = PH_RST_REL;
					end
				end
			end
			PH_RST_REL: begin
				// device let go of the line, or it stayed low too long
				if (line) begin
					tcount     = 0;
					r.done_res = 1'b1;
					r.status   = ST_OK;
					ph         = PH_IDLE;
				end else if (slot_over(timing.release_timeout)) begin
					r.done_res = 1'b1;
					r.status   = ST_STUCK_LOW;
					ph         = PH_IDLE;
				end
			end
			PH_W_LOW: begin
				r.drive_low = 1'b1;
				if (slot_over(shreg[0] ? timing.short_slot_time : timing.long_slot_time))
					ph = PH_W_HIGH;
			end
			PH_W_HIGH: begin
				if (slot_over(shreg[0] ? timing.long_slot_time : timing.short_slot_time)) begin
					shreg = shreg >> 1;
					if (bcount == 3'd7) begin
						r.done_res = 1'b1;
						ph         = PH_IDLE;
					end else begin
						bcount++;
						ph = PH_W_LOW;
					end
				end
			end
			PH_R_LOW: begin
				r.drive_low = 1'b1;
				if (slot_over(timing.read_low_time))
					ph = PH_R_WAIT;
			end
			PH_R_WAIT: begin
				if (slot_over(timing.read_sample_time)) begin
					shreg = {line, shreg[7:1]};
					ph    = PH_R_REC;
				end
			end
			PH_R_REC: begin
				if (slot_over(timing.read_recovery_time)) begin
					if (bcount == 3'd7) begin
						r.done_res = 1'b1;
						r.rx_byte  = shreg;
						ph         = PH_IDLE;
					end else begin
						bcount++;
						ph = PH_R_LOW;
					end
				end
			end
			default: begin
				ph         = PH_IDLE;
				tcount     = 0;
				r.busy_res = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// compare results, predict accepted ticks, then track register writes
	always @(posedge clk or negedge arst_n) begin : watch
		res_t got;
		res_t want;
		if (!arst_n) begin
			timing.reset_low_time       = RST_RESET_LOW;
			timing.presence_sample_time = RST_PRESENCE;
			timing.release_timeout      = RST_RELEASE;
			timing.short_slot_time      = RST_SHORT_SLOT;
			timing.long_slot_time       = RST_LONG_SLOT;
			timing.read_low_time        = RST_READ_LOW;
			timing.read_sample_time     = RST_READ_SAMPLE;
			timing.read_recovery_time   = RST_READ_RECOVERY;
			ph            = PH_IDLE;
			tcount        = 0;
			bcount        = '0;
			shreg         = '0;
			kind          = ACT_TICK;
			errors        = 0;
			resets_ok     = 0;
			resets_absent = 0;
			resets_stuck  = 0;
			bytes_written = 0;
			bytes_read    = 0;
			tick_results_q.delete();
			outstanding <= 0;
			seq_busy    <= 1'b0;
		end else begin
			// result transfer
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[12:0]);
				if (tick_results_q.size() == 0) begin
					$error("result transfer with no tick outstanding: m_tdata %h", m_tdata);
					errors++;
				end else begin
					want = tick_results_q.pop_front();
					check_field("drive_low", want.drive_low, got.drive_low);
					check_field("busy_res", want.busy_res, got.busy_res);
					check_field("done_res", want.done_res, got.done_res);
					check_field("status", want.status, got.status);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
				end
				check_field("m_tdata padding", 8'h00, m_tdata[15:13]);
			end

			// tick transfer, seen with the timing in force before this edge
			if (s_tvalid && s_tready) begin
				want = bus_tick(action_t'(s_tuser), s_tdata[7:0], s_tdata[8]);
				tick_results_q.push_back(want);
				if (want.done_res) begin
					case (kind)
						ACT_RESET: begin
							if (want.status == ST_OK)
								resets_ok++;
							else if (want.status == ST_NO_PRESENCE)
								resets_absent++;
							else
								resets_stuck++;
						end
						ACT_WRITE: bytes_written++;
						default:   bytes_read++;
					endcase
				end
			end

			// register write
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
					REG_RESET_LOW:     timing.reset_low_time       = pwdata[9:0];
					REG_PRESENCE:      timing.presence_sample_time = pwdata[7:0];
					REG_RELEASE:       timing.release_timeout      = pwdata[9:0];
					REG_SHORT_SLOT:    timing.short_slot_time      = pwdata[5:0];
					REG_LONG_SLOT:     timing.long_slot_time       = pwdata[7:0];
					REG_READ_LOW:      timing.read_low_time        = pwdata[5:0];
					REG_READ_SAMPLE:   timing.read_sample_time     = pwdata[5:0];
					REG_READ_RECOVERY: timing.read_recovery_time   = pwdata[7:0];
					default: ;
				endcase
			end

			outstanding <= tick_results_q.size();
			seq_busy    <= (ph != PH_IDLE);
		end
	end

endmodule

// ===== tb/tb_onewire_bus_master.sv =====
`timescale 1ns / 100ps

module tb_onewire_bus_master;
	import onewb_pkg::*;

	localparam int CLK_HALF    = 5;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int STUCK_LINE  = 100000;

	typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [31:0]           pwdata  = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata  = '0;  // tx_byte[7:0], line_level[8], zero
	logic [1:0]            s_tuser  = '0;  // action[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;        // drive_low, busy_res, done_res,
	                                       // status[4:3], rx_byte[12:5], zero

	int   fail_count;
	int   outstanding;
	logic seq_busy;
	int   resets_ok, resets_absent, resets_stuck, bytes_written, bytes_read;

	cfg_t        timing_now;
	int unsigned burst_left = 0;
	int unsigned line_run   = 0;
	logic        line_lvl   = 1'b1;
	int unsigned ticks_sent = 0;
	int unsigned cycles     = 0;
	int unsigned hold_req   = 0;

	onewire_bus_master DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	onewire_bus_master_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.errors        (fail_count),
		.outstanding   (outstanding),
		.seq_busy      (seq_busy),
		.resets_ok     (resets_ok),
		.resets_absent (resets_absent),
		.resets_stuck  (resets_stuck),
		.bytes_written (bytes_written),
		.bytes_read    (bytes_read)
	);

	// clock
	always #(CLK_HALF) clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side backpressure, plus long hold-offs on request
	initial begin : receiver
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned hold_left;
		logic [7:0]  pattern;
		logic        ready;
		mode      = RX_STEADY;
		mode_left = 0;
		hold_left = 0;
		pattern   = 8'hFF;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
				pattern   = 8'($urandom) | 8'h01;
			end
			mode_left--;
			if (hold_left != 0) begin
				ready = 1'b0;
				hold_left--;
			end else begin
				case (mode)
					RX_STEADY:  ready = 1'b1;
					RX_COIN:    ready = 1'($urandom_range(0, 1));
					RX_PATTERN: begin
						ready   = pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
					default:    ready = ($urandom_range(0, 3) != 0);
				endcase
			end
			m_tready <= ready;
		end
	end

	function automatic int unsigned cap(input int unsigned a, input int unsigned b);
		return (a < b) ? a : b;
	endfunction

	// a zero length register still lasts one tick
	function automatic int unsigned span(input int unsigned len);
		return (len == 0) ? 1 : len;
	endfunction

	function automatic cfg_t pick_timing(input int unsigned most);
		cfg_t c;
		c.reset_low_time       = 10'($urandom_range(1, cap(most, 1023)));
		c.presence_sample_time = 8'($urandom_range(1, cap(most, 255)));
		c.release_timeout      = 10'($urandom_range(1, cap(most, 1023)));
		c.short_slot_time      = 6'($urandom_range(1, cap(most, 63)));
		c.long_slot_time       = 8'($urandom_range(1, cap(most, 255)));
		c.read_low_time        = 6'($urandom_range(1, cap(most, 63)));
		c.read_sample_time     = 6'($urandom_range(1, cap(most, 63)));
		c.read_recovery_time   = 8'($urandom_range(1, cap(most, 255)));
		return c;
	endfunction

	// bus level in runs of random length
	function automatic logic next_line();
		if (line_run == 0) begin
			line_lvl = 1'($urandom_range(0, 1));
			line_run = $urandom_range(1, 12);
		end
		line_run--;
		return line_lvl;
	endfunction

	// offer one tick and hold it until the transfer, with bursts and gaps
	task automatic send_tick(input action_t act, input logic [7:0] tx, input logic line);
		int unsigned gap;
		if (burst_left == 0) begin
			case ($urandom_range(0, 9))
				0, 1, 2: gap = 0;
				9:       gap = $urandom_range(8, 25);
				default: gap = $urandom_range(1, 4);
			endcase
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, line, tx};
		s_tuser  <= act;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		ticks_sent++;
	endtask

	task automatic random_ticks(input int n);
		repeat (n) send_tick(action_t'($urandom_range(0, 3)), 8'($urandom), next_line());
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		s_tvalid   <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// tick until the bus operation is over, then drain
	task automatic settle();
		do send_tick(ACT_TICK, 8'($urandom), next_line()); while (seq_busy);
		drain_results();
		repeat (4) @(posedge clk);
	endtask

	// one command, then ticks with the line low for the first low_ticks ticks;
	// the second tick carries a command that must be ignored
	task automatic directed_op(input action_t act, input logic [7:0] tx, input int low_ticks);
		int k;
		k = 0;
		send_tick(act, tx, (k < low_ticks) ? 1'b0 : 1'b1);
		do begin
			k++;
			send_tick((k == 1) ? action_t'($urandom_range(1, 3)) : ACT_TICK, 8'($urandom),
				(k < low_ticks) ? 1'b0 : 1'b1);
		end while (seq_busy);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write all timing registers, optionally with junk above each field
	task automatic load_timing(input cfg_t c, input bit noisy);
		logic [31:0] field [8];
		int unsigned w [8];
		logic [31:0] upper;
		field[REG_RESET_LOW]     = 32'(c.reset_low_time);
		field[REG_PRESENCE]      = 32'(c.presence_sample_time);
		field[REG_RELEASE]       = 32'(c.release_timeout);
		field[REG_SHORT_SLOT]    = 32'(c.short_slot_time);
		field[REG_LONG_SLOT]     = 32'(c.long_slot_time);
		field[REG_READ_LOW]      = 32'(c.read_low_time);
		field[REG_READ_SAMPLE]   = 32'(c.read_sample_time);
		field[REG_READ_RECOVERY] = 32'(c.read_recovery_time);
		w[REG_RESET_LOW]         = $bits(c.reset_low_time);
		w[REG_PRESENCE]          = $bits(c.presence_sample_time);
		w[REG_RELEASE]           = $bits(c.release_timeout);
		w[REG_SHORT_SLOT]        = $bits(c.short_slot_time);
		w[REG_LONG_SLOT]         = $bits(c.long_slot_time);
		w[REG_READ_LOW]          = $bits(c.read_low_time);
		w[REG_READ_SAMPLE]       = $bits(c.read_sample_time);
		w[REG_READ_RECOVERY]     = $bits(c.read_recovery_time);
		for (int i = 0; i < 8; i++) begin
			upper = noisy ? (32'($urandom) << w[i]) : 32'h0;
			write_reg(reg_idx_t'(i), upper | field[i]);
		end
		timing_now = c;
	endtask

	// stimulus
	initial begin : stimulus
		cfg_t brief;
		int   presence_ticks;
		timing_now = {RST_RESET_LOW, RST_PRESENCE, RST_RELEASE, RST_SHORT_SLOT,
			RST_LONG_SLOT, RST_READ_LOW, RST_READ_SAMPLE, RST_READ_RECOVERY};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timings, the running operation finishes under the next load
		random_ticks(100);
		drain_results();

		// short timings: every reset outcome, byte extremes, reads of both levels
		brief = {10'd3, 8'd2, 10'd3, 6'd1, 8'd2, 6'd1, 6'd2, 8'd1};
		load_timing(brief, 1'b1);
		settle();
		presence_ticks = span(timing_now.reset_low_time) + span(timing_now.presence_sample_time);
		directed_op(ACT_RESET, 8'h00, 0);
		directed_op(ACT_RESET, 8'hFF, presence_ticks);
		directed_op(ACT_RESET, 8'h00, presence_ticks + 2);
		directed_op(ACT_RESET, 8'h00, STUCK_LINE);
		directed_op(ACT_WRITE, 8'h00, 0);
		directed_op(ACT_WRITE, 8'hFF, 0);
		directed_op(ACT_WRITE, 8'hA5, 0);
		directed_op(ACT_READ, 8'h00, 0);
		directed_op(ACT_READ, 8'hFF, STUCK_LINE);
		directed_op(ACT_READ, 8'h00, 9);
		send_tick(ACT_TICK, 8'hFF, 1'b0);
		send_tick(ACT_TICK, 8'h00, 1'b1);
		settle();

		// zero length registers behave as one tick
		load_timing('0, 1'b1);
		presence_ticks = span(timing_now.reset_low_time) + span(timing_now.presence_sample_time);
		directed_op(ACT_RESET, 8'h00, 0);
		directed_op(ACT_RESET, 8'h00, presence_ticks);
		directed_op(ACT_RESET, 8'h00, STUCK_LINE);
		directed_op(ACT_WRITE, 8'h3C, 0);
		directed_op(ACT_READ, 8'h00, 3);
		settle();

		// shortest legal timings
		load_timing({10'd1, 8'd1, 10'd1, 6'd1, 8'd1, 6'd1, 6'd1, 8'd1}, 1'b0);
		random_ticks(200);
		settle();

		// small timings, with a long result stall and a full pause
		load_timing(pick_timing(6), 1'b1);
		random_ticks(150);
		hold_req = 300;
		random_ticks(100);
		drain_results();
		random_ticks(150);
		settle();

		// longest timings, the running operation finishes under the next load
		load_timing('1, 1'b0);
		random_ticks(200);
		drain_results();

		// small timings again, another long stall
		load_timing(pick_timing(10), 1'b1);
		random_ticks(200);
		hold_req = 500;
		random_ticks(200);
		settle();

		// medium timings
		load_timing(pick_timing(40), 1'b1);
		random_ticks(250);

		drain_results();
		repeat (8) @(posedge clk);
		$display("ran %0d ticks over 8 timing settings, zero, minimum and maximum among them",
			ticks_sent);
		$display("completed %0d resets (%0d ok, %0d absent, %0d stuck low), %0d writes, %0d reads",
			resets_ok + resets_absent + resets_stuck, resets_ok, resets_absent, resets_stuck,
			bytes_written, bytes_read);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
